// ----- hdl/mexp_pkg.sv -----
// Shared types for the modular exponentiation block: states, commands, status.
package mexp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DBL,
      ST_ADD,
      ST_WB,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Which modular product is running: base reduction, acc*sq, or sq*sq
   typedef enum logic [1:0] {
      OP_BASE,
      OP_ACC,
      OP_SQ
   } op_type;

   typedef struct packed {
      logic   load;        // capture base and exponent
      logic   mul_start;   // clear product, load operands
      op_type mul_op;
      logic   step_dbl;    // product <= 2*product mod M
      logic   step_add;    // product <= product + addend mod M
      logic   bit_next;    // advance to next multiplier bit
      logic   wr_acc;
      logic   wr_sq;
      logic   exp_shift;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic in_exp_zero;
      logic mlt_msb;
      logic cnt_last;
      logic exp_lsb;
      logic exp_rest_zero;
   } status_type;

endpackage

// ----- hdl/mexp_dp.sv -----
// Datapath: operand registers, shared modular adder and bit-serial multiplier.
module mexp_dp
   import mexp_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic                 clock,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [WORD_BITS-1:0] modulus,
   input  logic [WORD_BITS-1:0] req_base,
   input  logic [WORD_BITS-1:0] req_exponent,
   output logic [WORD_BITS-1:0] rsp_residue
);

   localparam int CNT_W = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] sq_ff, sq_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS-1:0] add_ff, add_in;
   logic [WORD_BITS-1:0] mlt_ff, mlt_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [WORD_BITS:0]   mod_ext;
   logic [WORD_BITS:0]   add_y;
   logic [WORD_BITS:0]   add_sum;
   logic [WORD_BITS:0]   add_red;
   logic [WORD_BITS-1:0] one_res;

   // A zero modulus stands for 2^WORD_BITS
   assign mod_ext = (modulus == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus};
   assign one_res = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

   // Both operands stay below M, so the sum needs one subtract at most
   assign add_y   = cmd.step_add ? {1'b0, add_ff} : {1'b0, prod_ff};
   assign add_sum = {1'b0, prod_ff} + add_y;
   assign add_red = (add_sum >= mod_ext) ? (add_sum - mod_ext) : add_sum;

   always_comb begin
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      exp_in  = exp_ff;
      prod_in = prod_ff;
      add_in  = add_ff;
      mlt_in  = mlt_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      if (cmd.load) begin
         sq_in  = req_base;
         exp_in = req_exponent;
         acc_in = (req_exponent == '0) ? WORD_BITS'(1) : one_res;
      end
      if (cmd.mul_start) begin
         prod_in = '0;
         cnt_in  = '0;
         unique case (cmd.mul_op)
            OP_BASE: begin
               add_in = one_res;
               mlt_in = sq_ff;
            end
            OP_ACC: begin
               add_in = acc_ff;
               mlt_in = sq_ff;
            end
            OP_SQ: begin
               add_in = sq_ff;
               mlt_in = sq_ff;
            end
            default: begin
               add_in = sq_ff;
               mlt_in = sq_ff;
            end
         endcase
      end
      if (cmd.step_dbl || cmd.step_add) begin
         prod_in = add_red[WORD_BITS-1:0];
      end
      if (cmd.bit_next) begin
         mlt_in = {mlt_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.wr_acc) begin
         acc_in = prod_ff;
      end
      if (cmd.wr_sq) begin
         sq_in = prod_ff;
      end
      if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end
      if (cmd.out_load) begin
         res_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      exp_ff  <= exp_in;
      prod_ff <= prod_in;
      add_ff  <= add_in;
      mlt_ff  <= mlt_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign status.in_exp_zero   = (req_exponent == '0);
   assign status.mlt_msb       = mlt_ff[WORD_BITS-1];
   assign status.cnt_last      = (cnt_ff == CNT_W'(WORD_BITS - 1));
   assign status.exp_lsb       = exp_ff[0];
   assign status.exp_rest_zero = (exp_ff[WORD_BITS-1:1] == '0);

   assign rsp_residue = res_ff;

endmodule

// ----- hdl/mexp_ctrl.sv -----
// Controller: sequences base reduction, square-and-multiply and result hand-off.
module mexp_ctrl
   import mexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_op = OP_BASE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.in_exp_zero ? ST_DONE : ST_START;
            end
         end
         ST_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = OP_BASE;
            state_in      = ST_DBL;
         end
         ST_DBL: begin
            cmd.step_dbl = 1'b1;
            if (status.mlt_msb) begin
               state_in = ST_ADD;
            end else begin
               cmd.bit_next = 1'b1;
               state_in     = status.cnt_last ? ST_WB : ST_DBL;
            end
         end
         ST_ADD: begin
            cmd.step_add = 1'b1;
            cmd.bit_next = 1'b1;
            state_in     = status.cnt_last ? ST_WB : ST_DBL;
         end
         ST_WB: begin
            unique case (op_ff)
               OP_BASE: begin
                  cmd.wr_sq = 1'b1;
                  state_in  = ST_EVAL;
               end
               OP_ACC: begin
                  cmd.wr_acc = 1'b1;
                  // no higher exponent bits left: the square is not needed
                  if (status.exp_rest_zero) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.mul_start = 1'b1;
                     cmd.mul_op    = OP_SQ;
                     state_in      = ST_DBL;
                  end
               end
               default: begin
                  cmd.wr_sq     = 1'b1;
                  cmd.exp_shift = 1'b1;
                  state_in      = ST_EVAL;
               end
            endcase
         end
         ST_EVAL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = status.exp_lsb ? OP_ACC : OP_SQ;
            state_in      = ST_DBL;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      op_in = cmd.mul_start ? cmd.mul_op : op_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: modulus register, controller, datapath.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    req_base, req_exponent
//   rsp       out        rsp_valid/stall    rsp_residue
//   csr       in         csr_valid/ready    csr_modulus
//
// One modular multiply doubles for every multiplier bit and adds for every set bit,
// then writes back; one shared modular adder does a double or an add each cycle.
// An item takes a base reduction and up to two multiplies per exponent bit up to
// its highest set bit; a zero exponent skips them. Synchronous reset sets modulus to 65521.
// The next item is taken while a result waits in the output register under stall.
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_base,
   input  logic [WORD_BITS-1:0] req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_residue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WORD_BITS-1:0] csr_modulus
);

   localparam logic [WORD_BITS-1:0] ModulusReset = WORD_BITS'(65521);

   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   cmd_type              cmd;
   status_type           status;

   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= ModulusReset;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mexp_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .modulus      (modulus_ff),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_residue  (rsp_residue)
   );

   // one item at a time: a transfer in closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in flight");

   // zero exponent goes through ST_DONE to the output register and returns 1 when the output is free
   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_exponent == '0 && !rsp_valid)
         |=> ##1 (rsp_valid && rsp_residue == WORD_BITS'(1)))
      else $error("zero exponent did not give residue 1");

   // a fresh result lies below a nonzero modulus above one
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && modulus_ff > WORD_BITS'(1)) |-> (rsp_residue < modulus_ff))
      else $error("residue not reduced");

endmodule
